// ----- rtl/lzrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrd_pkg
// Shared types and constants for the LZSS ring decompressor.
// ----------------------------------------------------------------------------
package lzrd_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int FILL_W     = RING_AW + 1;
   localparam int LEN_W      = 5;
   localparam int LEN_BIAS   = 3;
   localparam int FLAG_IDX_W = 3;

   typedef logic [7:0]         byte_type;
   typedef logic [RING_AW-1:0] ring_addr_type;
   typedef logic [FILL_W-1:0]  fill_type;
   typedef logic [LEN_W-1:0]   len_type;

   localparam ring_addr_type WP_RESET = ring_addr_type'(12'hFEE);
   localparam logic [FLAG_IDX_W-1:0] FLAG_IDX_LAST = '1;

   typedef enum logic [1:0] {
      PH_CTRL   = 2'd0,
      PH_DATA   = 2'd1,
      PH_MATCH2 = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_READ  = 3'b010,
      S_WRITE = 3'b100
   } state_type;

endpackage

// ----- rtl/lzrd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrd_if
// Valid/ready channels for compressed input bytes and decompressed output.
// ----------------------------------------------------------------------------
interface lzrd_req_if;
   logic               valid;
   logic               ready;
   lzrd_pkg::byte_type in_byte;
   logic               in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzrd_rsp_if;
   logic               valid;
   logic               ready;
   lzrd_pkg::byte_type out_byte;
   logic               out_run_end;

   modport source (output valid, output out_byte, output out_run_end, input ready);
   modport sink   (input valid, input out_byte, input out_run_end, output ready);
endinterface

// ----- rtl/lzss_ring_decompressor_unit.sv -----
`timescale 1ns / 1ps
// Flow: a control or literal byte takes one transaction; a literal's output byte is registered.
// A match takes two bytes; then each match byte is read from the ring (S_READ), then written
// back and output (S_WRITE). No input is taken during a copy; a full output slot holds S_WRITE.
// Reset: synchronous; control state cleared, ring contents kept but masked by a fill
// count, so unwritten entries read as zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
// lzss_ring_decompressor_unit
// LZSS decoder with a 4096-byte history ring held in one synchronous RAM.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor_unit (
   input logic        clock,
   input logic        reset,
   lzrd_req_if.sink   req_chan,
   lzrd_rsp_if.source rsp_chan
);
   import lzrd_pkg::*;

   byte_type ring_mem [RING_DEPTH];

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   ring_addr_type wp_ff, wp_in;
   fill_type      fill_ff, fill_in;
   byte_type      flag_byte_ff, flag_byte_in;
   logic [FLAG_IDX_W-1:0] flag_idx_ff, flag_idx_in;
   byte_type      first_ff, first_in;
   ring_addr_type mpos_ff, mpos_in;
   len_type       mrem_ff, mrem_in;
   logic          last_ff, last_in;
   byte_type      rd_data_ff;
   logic          rd_ok_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   byte_type      rsp_byte_ff, rsp_byte_in;
   logic          rsp_end_ff, rsp_end_in;

   logic          slot_free, accept, rsp_load;
   logic          we;
   byte_type      wdata;
   ring_addr_type rd_ofs;
   logic          rd_ok;
   byte_type      copy_byte;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && slot_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign rd_ofs    = mpos_ff - WP_RESET;
   assign rd_ok     = {1'b0, rd_ofs} < fill_ff;
   assign copy_byte = rd_ok_ff ? rd_data_ff : '0;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      flag_byte_in = flag_byte_ff;
      flag_idx_in  = flag_idx_ff;
      first_in     = first_ff;
      mpos_in      = mpos_ff;
      mrem_in      = mrem_ff;
      last_in      = last_ff;
      rsp_load     = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      we           = 1'b0;
      wdata        = req_chan.in_byte;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  PH_DATA: begin
                     if (flag_byte_ff[flag_idx_ff]) begin
                        we          = 1'b1;
                        rsp_load    = 1'b1;
                        rsp_byte_in = req_chan.in_byte;
                        rsp_end_in  = 1'b1;
                        wp_in       = wp_ff + 1'b1;
                        fill_in     = fill_ff[RING_AW] ? fill_ff : fill_ff + 1'b1;
                        flag_idx_in = flag_idx_ff + 1'b1;
                        phase_in    = (flag_idx_ff == FLAG_IDX_LAST) ? PH_CTRL : PH_DATA;
                     end else begin
                        first_in = req_chan.in_byte;
                        phase_in = PH_MATCH2;
                     end
                  end
                  PH_MATCH2: begin
                     mpos_in     = {req_chan.in_byte[7:4], first_ff};
                     mrem_in     = len_type'(req_chan.in_byte[3:0]) + len_type'(LEN_BIAS);
                     last_in     = req_chan.in_last;
                     flag_idx_in = flag_idx_ff + 1'b1;
                     phase_in    = (flag_idx_ff == FLAG_IDX_LAST) ? PH_CTRL : PH_DATA;
                     state_in    = S_READ;
                  end
                  default: begin
                     flag_byte_in = req_chan.in_byte;
                     flag_idx_in  = '0;
                     phase_in     = PH_DATA;
                  end
               endcase
               if (req_chan.in_last && !(phase_ff == PH_MATCH2)) begin
                  phase_in     = PH_CTRL;
                  wp_in        = WP_RESET;
                  fill_in      = '0;
                  flag_byte_in = '0;
                  flag_idx_in  = '0;
                  first_in     = '0;
               end
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (slot_free) begin
               we          = 1'b1;
               wdata       = copy_byte;
               rsp_load    = 1'b1;
               rsp_byte_in = copy_byte;
               rsp_end_in  = (mrem_ff == len_type'(1));
               wp_in       = wp_ff + 1'b1;
               fill_in     = fill_ff[RING_AW] ? fill_ff : fill_ff + 1'b1;
               mpos_in     = mpos_ff + 1'b1;
               mrem_in     = mrem_ff - 1'b1;
               if (mrem_ff == len_type'(1)) begin
                  state_in = S_IDLE;
                  if (last_ff) begin
                     phase_in     = PH_CTRL;
                     wp_in        = WP_RESET;
                     fill_in      = '0;
                     flag_byte_in = '0;
                     flag_idx_in  = '0;
                     first_in     = '0;
                  end
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         ring_mem[wp_ff] <= wdata;
      end
      if (state_ff == S_READ) begin
         rd_data_ff <= ring_mem[mpos_ff];
         rd_ok_ff   <= rd_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_CTRL;
         wp_ff        <= WP_RESET;
         fill_ff      <= '0;
         flag_byte_ff <= '0;
         flag_idx_ff  <= '0;
         first_ff     <= '0;
         mrem_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         flag_byte_ff <= flag_byte_in;
         flag_idx_ff  <= flag_idx_in;
         first_ff     <= first_in;
         mrem_ff      <= mrem_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mpos_ff     <= mpos_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_byte_ff;
   assign rsp_chan.out_run_end = rsp_end_ff;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives compressed LZSS streams into lzss_ring_decompressor_unit and checks
// every decompressed byte against a behavioral decoder kept in the bench.
// Streams mix literals, short and long matches, overlapping and wrapping
// copies, and endings cut on control bytes or half matches. Both channels
// idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
   import lzrd_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int ITEM_TARGET  = 350;
   localparam int CALM_ITEMS   = 40;
   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT  = 4000;

   typedef struct {
      byte_type data;
      logic     last;
   } stream_byte_type;

   typedef struct {
      byte_type data;
      logic     run_end;
   } plain_byte_type;

   logic clock;
   logic reset;

   lzrd_req_if req_bus ();
   lzrd_rsp_if rsp_bus ();

   lzss_ring_decompressor_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   stream_byte_type pending_bytes[$];
   plain_byte_type  expected_bytes[$];

   // decoder state
   byte_type      history[RING_DEPTH];
   ring_addr_type wr_pos;
   byte_type      flag_bits;
   logic [2:0]    flag_pos;
   phase_type     phase;
   byte_type      match_lo;

   ring_addr_type gen_wp;

   int unsigned   error_count;
   int unsigned   bytes_sent;
   int unsigned   bytes_checked;
   int unsigned   stream_count;
   int unsigned   match_count;
   int unsigned   cycle_count;
   int unsigned   stall_cycles;
   int unsigned   send_gap;
   int unsigned   hold_gap;
   int unsigned   send_rate;
   int unsigned   hold_rate;
   logic          calm;
   stream_byte_type next_byte;
   plain_byte_type  want;

   function automatic void note_error(input string what);
      error_count++;
      if (error_count <= 10)
         $display("%0t ns: %s", $time, what);
   endfunction

   function automatic int unsigned pick_rate();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 4;
         2: return 12;
         default: return 30;
      endcase
   endfunction

   function automatic void clear_history();
      foreach (history[i])
         history[i] = '0;
      wr_pos    = WP_RESET;
      flag_bits = '0;
      flag_pos  = '0;
      phase     = PH_CTRL;
      match_lo  = '0;
   endfunction

   function automatic void advance_flag();
      if (flag_pos == FLAG_IDX_LAST) begin
         flag_pos = '0;
         phase    = PH_CTRL;
      end else begin
         flag_pos = flag_pos + 1'b1;
         phase    = PH_DATA;
      end
   endfunction

   function automatic void decode_byte(input byte_type b, input logic last);
      ring_addr_type  src;
      int unsigned    run_len;
      plain_byte_type r;
      case (phase)
         PH_DATA: begin
            if (flag_bits[flag_pos]) begin
               history[wr_pos] = b;
               wr_pos          = wr_pos + 1'b1;
               r.data          = b;
               r.run_end       = 1'b1;
               expected_bytes.push_back(r);
               advance_flag();
            end else begin
               match_lo = b;
               phase    = PH_MATCH2;
            end
         end
         PH_MATCH2: begin
            src     = {b[7:4], match_lo};
            run_len = int'(b[3:0]) + LEN_BIAS;
            for (int unsigned k = 0; k < run_len; k++) begin
               r.data          = history[src];
               r.run_end       = (k == run_len - 1);
               history[wr_pos] = r.data;
               wr_pos          = wr_pos + 1'b1;
               src             = src + 1'b1;
               expected_bytes.push_back(r);
            end
            advance_flag();
         end
         default: begin
            flag_bits = b;
            flag_pos  = '0;
            phase     = PH_DATA;
         end
      endcase
      if (last)
         clear_history();
   endfunction

   task automatic push_byte(input byte_type b, input logic last);
      stream_byte_type s;
      s.data = b;
      s.last = last;
      pending_bytes.push_back(s);
   endtask

   // mostly short back references so copies land on written history
   task automatic push_match(input int unsigned run_len, input logic last);
      ring_addr_type pos;
      int unsigned   mode;
      mode = $urandom_range(0, 9);
      if (mode < 5)
         pos = gen_wp - ring_addr_type'($urandom_range(1, 40));
      else if (mode < 8)
         pos = gen_wp - ring_addr_type'($urandom_range(1, run_len));
      else
         pos = ring_addr_type'($urandom);
      push_byte(pos[7:0], 1'b0);
      push_byte({pos[11:8], 4'(run_len - LEN_BIAS)}, last);
      gen_wp = gen_wp + ring_addr_type'(run_len);
      match_count++;
   endtask

   task automatic gen_stream();
      int unsigned groups;
      int unsigned flags_used;
      byte_type    ctrl;
      gen_wp = WP_RESET;
      groups = $urandom_range(1, 6);
      for (int unsigned g = 0; g < groups; g++) begin
         ctrl       = byte_type'($urandom);
         flags_used = (g == groups - 1) ? $urandom_range(1, 8) : 8;
         push_byte(ctrl, 1'b0);
         for (int unsigned i = 0; i < flags_used; i++) begin
            if (ctrl[i]) begin
               push_byte(byte_type'($urandom), 1'b0);
               gen_wp = gen_wp + 1'b1;
            end else begin
               push_match($urandom_range(LEN_BIAS, 18), 1'b0);
            end
         end
      end
      case ($urandom_range(0, 3))
         0, 1: pending_bytes[pending_bytes.size() - 1].last = 1'b1;
         2:    push_byte(byte_type'($urandom), 1'b1);
         default: begin
            // trailing garbage, ended by a final byte
            repeat ($urandom_range(1, 10))
               push_byte(byte_type'($urandom), 1'b0);
            pending_bytes[pending_bytes.size() - 1].last = 1'b1;
         end
      endcase
      stream_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.in_byte <= '0;
         req_bus.in_last <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count % 256 == 0)
            send_rate = pick_rate();
         calm = (pending_bytes.size() < CALM_ITEMS);
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.in_byte, req_bus.in_last);
            bytes_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0 && !calm) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_bytes.size() != 0 &&
                         (calm || $urandom_range(0, 99) >= send_rate)) begin
               next_byte = pending_bytes.pop_front();
               req_bus.in_byte <= next_byte.data;
               req_bus.in_last <= next_byte.last;
               req_bus.valid   <= 1'b1;
            end else begin
               if (pending_bytes.size() != 0)
                  send_gap = $urandom_range(0, 14);
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (cycle_count % 256 == 128)
            hold_rate = pick_rate();
         if (rsp_bus.valid && rsp_bus.ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               note_error($sformatf("unexpected output byte %02h run_end %0b",
                                    rsp_bus.out_byte, rsp_bus.out_run_end));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_bus.out_byte !== want.data)
                  note_error($sformatf("out_byte expected %02h got %02h",
                                       want.data, rsp_bus.out_byte));
               if (rsp_bus.out_run_end !== want.run_end)
                  note_error($sformatf("out_run_end expected %0b got %0b (byte %02h)",
                                       want.run_end, rsp_bus.out_run_end, want.data));
            end
         end
         if (hold_gap != 0 && !calm) begin
            hold_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < hold_rate) begin
            hold_gap = $urandom_range(0, 14);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else if (pending_bytes.size() != 0 || req_bus.valid ||
                   expected_bytes.size() != 0) begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction", stall_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.in_byte = '0;
      req_bus.in_last = 1'b0;
      rsp_bus.ready   = 1'b0;
      reset           = 1'b1;
      error_count     = 0;
      bytes_sent      = 0;
      bytes_checked   = 0;
      stream_count    = 0;
      match_count     = 0;
      cycle_count     = 0;
      stall_cycles    = 0;
      send_gap        = 0;
      hold_gap        = 0;
      send_rate       = 4;
      hold_rate       = 4;
      calm            = 1'b0;
      clear_history();

      // all literals, byte extremes, full flag group
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'hFE, 1'b0);
      // matches: position 0 shortest, top of ring longest with wrap, overlapping copy
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h0A, 1'b0);
      push_byte(8'h0F, 1'b0);
      // final byte on half a match, then on a control byte, then on a literal
      push_byte(8'h34, 1'b1);
      push_byte(8'h01, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'h7E, 1'b1);
      // final byte on the second half of a match
      push_byte(8'h00, 1'b0);
      push_byte(8'hEE, 1'b0);
      push_byte(8'hFF, 1'b1);
      match_count = 4;

      while (pending_bytes.size() < ITEM_TARGET)
         gen_stream();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_bus.valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d compressed bytes in %0d streams with %0d matches.",
               bytes_sent, stream_count, match_count);
      $display("Checked %0d decompressed bytes, %0d mismatches.",
               bytes_checked, error_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
